FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the checker RTL.
// Needs the asserting module to have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// pre holds -> post holds in the same cycle
`define CPC_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// pre holds -> post holds in the next cycle
`define CPC_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define CPC_ASSERT_IMP(lbl, pre, post, msg)
`define CPC_ASSERT_NXT(lbl, pre, post, msg)

`endif

`endif

FILE: rtl/core/cpc_pkg.sv
// Shared types, codes and modular helpers for the progression checker.
// No dependencies.
package cpc_pkg;

    localparam int MAX_CELLS = 128;
    localparam int ADDR_W    = $clog2(MAX_CELLS);
    localparam int AP_W      = ADDR_W + 1;
    localparam int N_W       = $clog2(MAX_CELLS + 1);
    localparam int CFG_W     = 8;
    localparam int K_W       = 8;
    localparam int SUM_W     = K_W + 1;
    localparam int POS_W     = 7;
    localparam int CMP_W     = 9;
    localparam int COLOR_W   = 2;
    localparam int KIND_W    = 2;

    typedef logic [COLOR_W-1:0] t_color;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [KIND_W-1:0]  t_kind;

    localparam t_kind KIND_WRITE  = 2'd0;
    localparam t_kind KIND_WINNER = 2'd1;
    localparam t_kind KIND_MEMBER = 2'd2;
    localparam t_kind KIND_ROTATE = 2'd3;

    localparam t_color COLOR_EMPTY = 2'd0;

    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   position;
        t_color             color;
    } t_cmd;

    // effective board geometry after saturation
    typedef struct packed {
        logic [N_W-1:0]     n;
        t_addr              nm1;
        logic [K_W-1:0]     km1;
    } t_geom;

    typedef struct packed {
        logic               we;
        t_addr              waddr;
        t_color             wdata;
        t_addr              raddr;
    } t_mem_req;

    typedef struct packed {
        logic               valid;
        logic               found;
        t_color             color;
    } t_result;

    // (a + b) mod n, with a, b < n
    function automatic t_addr add_mod(t_addr a, t_addr b, logic [N_W-1:0] n);
        logic [AP_W-1:0] s;
        s = AP_W'(a) + AP_W'(b);
        if (s >= AP_W'(n)) begin
            s = s - AP_W'(n);
        end
        return s[ADDR_W-1:0];
    endfunction

    // (a - b) mod n, with a, b < n
    function automatic t_addr sub_mod(t_addr a, t_addr b, logic [N_W-1:0] n);
        logic [AP_W-1:0] s;
        if (a >= b) begin
            s = AP_W'(a) - AP_W'(b);
        end else begin
            s = AP_W'(a) + AP_W'(n) - AP_W'(b);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

FILE: rtl/core/cpc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cpc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/cpc_board.sv
// Cell store: RAM plus per-cell valid bits so the board reads empty after reset.
// Depends on cpc_pkg and cpc_ram.
module cpc_board import cpc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_color   o_rdata
);

    logic [MAX_CELLS-1:0] r_valid;
    logic                 r_rd_vld;
    t_color               ram_q;

    cpc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAX_CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.we),
        .i_waddr (i_req.waddr),
        .i_wdata (i_req.wdata),
        .i_raddr (i_req.raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            r_rd_vld <= r_valid[i_req.raddr];
        end
    end

    // never-written cell reads as empty
    assign o_rdata = r_rd_vld ? ram_q : COLOR_EMPTY;

endmodule

FILE: rtl/core/cpc_ctrl.sv
// Sequencer: write, rotate sweep, winner scan and membership walk over the cell RAM.
// Depends on cpc_pkg.
module cpc_ctrl import cpc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_cmd     i_cmd,
    input  t_geom    i_geom,
    input  t_color   i_rdata,
    output t_mem_req o_req,
    output logic     o_busy,
    output t_result  o_res
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ROT0     = 4'd1;
    localparam logic [3:0] S_ROT1     = 4'd2;
    localparam logic [3:0] S_ROT_SH   = 4'd3;
    localparam logic [3:0] S_ROT_END  = 4'd4;
    localparam logic [3:0] S_WIN_RDI  = 4'd5;
    localparam logic [3:0] S_WIN_GETC = 4'd6;
    localparam logic [3:0] S_WIN_RUN  = 4'd7;
    localparam logic [3:0] S_MEM_RD   = 4'd8;
    localparam logic [3:0] S_MEM_GETC = 4'd9;
    localparam logic [3:0] S_MEM_ISS  = 4'd10;
    localparam logic [3:0] S_MEM_CHK  = 4'd11;

    logic [3:0]     r_state, n_state;
    logic           r_pend, n_pend;
    logic           r_pend_last, n_pend_last;
    logic           r_iss_act, n_iss_act;
    logic           r_res_vld, n_res_vld;
    logic           r_res_found, n_res_found;
    t_color         r_res_color, n_res_color;
    t_color         r_c, n_c;
    t_color         r_first, n_first;
    t_addr          r_i, n_i;
    t_addr          r_t, n_t;
    t_addr          r_loc, n_loc;
    t_addr          r_d, n_d;
    t_addr          r_dk, n_dk;
    t_addr          r_base, n_base;
    t_addr          r_addr, n_addr;
    t_addr          r_jd, n_jd;
    logic [K_W-1:0] r_iss_j, n_iss_j;
    logic [K_W-1:0] r_run, n_run;
    logic           r_dir_right, n_dir_right;

    t_mem_req       req;
    logic           pos_in;
    logic           d_first_ok;
    logic           more_d;
    logic           mism;
    logic           last_i;
    logic           k_is_two;
    logic [AP_W-1:0] jd_next;
    t_addr          nb;
    t_addr          d_inc;

    assign pos_in     = CMP_W'(i_cmd.position) < CMP_W'(i_geom.n);
    assign d_first_ok = SUM_W'(i_geom.km1) <= SUM_W'(i_geom.nm1);
    // next difference still allowed: (d+1)(k-1) <= n-1
    assign more_d     = (SUM_W'(r_dk) + SUM_W'(i_geom.km1)) <= SUM_W'(i_geom.nm1);
    assign mism       = r_pend && (i_rdata != r_c);
    assign last_i     = (r_i == i_geom.nm1);
    assign k_is_two   = (i_geom.km1 == K_W'(1));
    assign jd_next    = AP_W'(r_jd) + AP_W'(r_d);
    assign nb         = add_mod(r_base, ADDR_W'(1), i_geom.n);
    assign d_inc      = r_d + ADDR_W'(1);

    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_iss_act   = r_iss_act;
        n_res_vld   = 1'b0;
        n_res_found = r_res_found;
        n_res_color = r_res_color;
        n_c         = r_c;
        n_first     = r_first;
        n_i         = r_i;
        n_t         = r_t;
        n_loc       = r_loc;
        n_d         = r_d;
        n_dk        = r_dk;
        n_base      = r_base;
        n_addr      = r_addr;
        n_jd        = r_jd;
        n_iss_j     = r_iss_j;
        n_run       = r_run;
        n_dir_right = r_dir_right;
        req         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_cmd.kind)
                        KIND_WRITE: begin
                            if (pos_in) begin
                                req.we    = 1'b1;
                                req.waddr = i_cmd.position[ADDR_W-1:0];
                                req.wdata = i_cmd.color;
                            end
                        end
                        KIND_ROTATE: begin
                            n_state = S_ROT0;
                        end
                        KIND_WINNER: begin
                            n_i     = '0;
                            n_state = S_WIN_RDI;
                        end
                        KIND_MEMBER: begin
                            if (pos_in) begin
                                n_loc   = i_cmd.position[ADDR_W-1:0];
                                n_state = S_MEM_RD;
                            end else begin
                                n_res_vld   = 1'b1;
                                n_res_found = 1'b0;
                                n_res_color = COLOR_EMPTY;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // rotate: hold cell 0, shift cells down, then drop it at n-1
            S_ROT0: begin
                req.raddr = '0;
                n_state   = S_ROT1;
            end
            S_ROT1: begin
                n_first   = i_rdata;
                req.raddr = ADDR_W'(1);
                n_t       = ADDR_W'(1);
                n_state   = S_ROT_SH;
            end
            S_ROT_SH: begin
                req.we    = 1'b1;
                req.waddr = r_t - ADDR_W'(1);
                req.wdata = i_rdata;
                if (r_t == i_geom.nm1) begin
                    n_state = S_ROT_END;
                end else begin
                    req.raddr = r_t + ADDR_W'(1);
                    n_t       = r_t + ADDR_W'(1);
                end
            end
            S_ROT_END: begin
                req.we    = 1'b1;
                req.waddr = i_geom.nm1;
                req.wdata = r_first;
                n_state   = S_IDLE;
            end

            S_WIN_RDI: begin
                req.raddr = r_i;
                n_state   = S_WIN_GETC;
            end
            S_WIN_GETC: begin
                if ((i_rdata == COLOR_EMPTY) || !d_first_ok) begin
                    if (last_i) begin
                        n_res_vld   = 1'b1;
                        n_res_found = 1'b0;
                        n_res_color = COLOR_EMPTY;
                        n_state     = S_IDLE;
                    end else begin
                        n_i     = r_i + ADDR_W'(1);
                        n_state = S_WIN_RDI;
                    end
                end else begin
                    n_c       = i_rdata;
                    n_d       = ADDR_W'(1);
                    n_dk      = i_geom.km1[ADDR_W-1:0];
                    n_base    = add_mod(r_i, ADDR_W'(1), i_geom.n);
                    n_addr    = add_mod(r_i, ADDR_W'(1), i_geom.n);
                    n_iss_j   = K_W'(1);
                    n_iss_act = 1'b1;
                    n_pend    = 1'b0;
                    n_state   = S_WIN_RUN;
                end
            end
            // one read issued per cycle; a mismatch restarts at the next
            // difference in the same cycle, dropping the read in flight
            S_WIN_RUN: begin
                if (r_pend && !mism && r_pend_last) begin
                    n_res_vld   = 1'b1;
                    n_res_found = 1'b1;
                    n_res_color = r_c;
                    n_pend      = 1'b0;
                    n_iss_act   = 1'b0;
                    n_state     = S_IDLE;
                end else if (mism) begin
                    if (more_d) begin
                        n_d         = d_inc;
                        n_dk        = r_dk + i_geom.km1[ADDR_W-1:0];
                        n_base      = nb;
                        req.raddr   = nb;
                        n_pend      = 1'b1;
                        n_pend_last = k_is_two;
                        n_addr      = add_mod(nb, d_inc, i_geom.n);
                        n_iss_j     = K_W'(2);
                        n_iss_act   = !k_is_two;
                    end else begin
                        n_pend    = 1'b0;
                        n_iss_act = 1'b0;
                        if (last_i) begin
                            n_res_vld   = 1'b1;
                            n_res_found = 1'b0;
                            n_res_color = COLOR_EMPTY;
                            n_state     = S_IDLE;
                        end else begin
                            n_i     = r_i + ADDR_W'(1);
                            n_state = S_WIN_RDI;
                        end
                    end
                end else if (r_iss_act) begin
                    req.raddr   = r_addr;
                    n_pend      = 1'b1;
                    n_pend_last = (r_iss_j == i_geom.km1);
                    n_addr      = add_mod(r_addr, r_d, i_geom.n);
                    n_iss_j     = r_iss_j + K_W'(1);
                    n_iss_act   = (r_iss_j != i_geom.km1);
                end else begin
                    n_pend = 1'b0;
                end
            end

            S_MEM_RD: begin
                req.raddr = r_loc;
                n_state   = S_MEM_GETC;
            end
            S_MEM_GETC: begin
                n_c = i_rdata;
                if (!d_first_ok) begin
                    n_res_vld   = 1'b1;
                    n_res_found = 1'b0;
                    n_res_color = COLOR_EMPTY;
                    n_state     = S_IDLE;
                end else begin
                    n_d         = ADDR_W'(1);
                    n_dk        = i_geom.km1[ADDR_W-1:0];
                    n_run       = K_W'(1);
                    n_dir_right = 1'b0;
                    n_jd        = ADDR_W'(1);
                    n_addr      = sub_mod(r_loc, ADDR_W'(1), i_geom.n);
                    n_state     = S_MEM_ISS;
                end
            end
            S_MEM_ISS: begin
                req.raddr = r_addr;
                n_state   = S_MEM_CHK;
            end
            S_MEM_CHK: begin
                if ((i_rdata == r_c) && (r_run >= i_geom.km1)) begin
                    n_res_vld   = 1'b1;
                    n_res_found = 1'b1;
                    n_res_color = COLOR_EMPTY;
                    n_state     = S_IDLE;
                end else if ((i_rdata == r_c) && (jd_next <= AP_W'(i_geom.nm1))) begin
                    n_run   = r_run + K_W'(1);
                    n_jd    = jd_next[ADDR_W-1:0];
                    n_addr  = r_dir_right ? add_mod(r_addr, r_d, i_geom.n)
                                          : sub_mod(r_addr, r_d, i_geom.n);
                    n_state = S_MEM_ISS;
                end else begin
                    if (i_rdata == r_c) begin
                        n_run = r_run + K_W'(1);
                    end
                    if (!r_dir_right) begin
                        n_dir_right = 1'b1;
                        n_jd        = r_d;
                        n_addr      = add_mod(r_loc, r_d, i_geom.n);
                        n_state     = S_MEM_ISS;
                    end else if (more_d) begin
                        n_d         = d_inc;
                        n_dk        = r_dk + i_geom.km1[ADDR_W-1:0];
                        n_run       = K_W'(1);
                        n_dir_right = 1'b0;
                        n_jd        = d_inc;
                        n_addr      = sub_mod(r_loc, d_inc, i_geom.n);
                        n_state     = S_MEM_ISS;
                    end else begin
                        n_res_vld   = 1'b1;
                        n_res_found = 1'b0;
                        n_res_color = COLOR_EMPTY;
                        n_state     = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_iss_act <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_iss_act <= n_iss_act;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_last <= n_pend_last;
        r_res_found <= n_res_found;
        r_res_color <= n_res_color;
        r_c         <= n_c;
        r_first     <= n_first;
        r_i         <= n_i;
        r_t         <= n_t;
        r_loc       <= n_loc;
        r_d         <= n_d;
        r_dk        <= n_dk;
        r_base      <= n_base;
        r_addr      <= n_addr;
        r_jd        <= n_jd;
        r_iss_j     <= n_iss_j;
        r_run       <= n_run;
        r_dir_right <= n_dir_right;
    end

    assign o_req       = req;
    assign o_busy      = (r_state != S_IDLE);
    assign o_res.valid = r_res_vld;
    assign o_res.found = r_res_found;
    assign o_res.color = r_res_color;

endmodule

FILE: rtl/core/cyclic_progression_color_checker.sv
// Write: taken while idle, busy stays low. Rotate: one RAM read and write a cycle.
// Winner query: steps past each empty start cell, else tries each spacing from that cell;
// membership: walks cells left, then right, of the position for each spacing.
// One item at a time: start is taken again once busy drops. The single RAM read port
// paces these steps; the result strobe lasts one cycle and cannot be stalled.
// Synchronous active-low reset restores n=8, k=3 and makes every cell read empty.
`include "assert_macros.svh"

module cyclic_progression_color_checker import cpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_kind              i_kind,
    input  logic [POS_W-1:0]   i_position,
    input  t_color             i_color,
    output logic               o_result_valid,
    output logic               o_found,
    output t_color             o_winning_color,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_wdata
);

    localparam logic CFG_BOARD_SIZE = 1'b0;
    localparam logic CFG_PROG_LEN   = 1'b1;

    logic [CFG_W-1:0] r_board_size;
    logic [CFG_W-1:0] r_prog_len;
    t_geom            geom;
    t_cmd             cmd;
    t_mem_req         mem_req;
    t_color           mem_rdata;
    t_result          res;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_size <= CFG_W'(8);
            r_prog_len   <= CFG_W'(3);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BOARD_SIZE: r_board_size <= i_cfg_wdata;
                CFG_PROG_LEN:   r_prog_len   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // saturate n into [3, MAX_CELLS], k to at least 2
    always_comb begin
        if (r_board_size < CFG_W'(3)) begin
            geom.n = N_W'(3);
        end else if (CMP_W'(r_board_size) > CMP_W'(MAX_CELLS)) begin
            geom.n = N_W'(MAX_CELLS);
        end else begin
            geom.n = N_W'(r_board_size);
        end
        geom.nm1 = ADDR_W'(geom.n - N_W'(1));
        geom.km1 = (r_prog_len < CFG_W'(2)) ? K_W'(1) : K_W'(r_prog_len - CFG_W'(1));
    end

    assign accept       = start && !busy;
    assign cmd.kind     = i_kind;
    assign cmd.position = i_position;
    assign cmd.color    = i_color;

    cpc_board u_board (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    cpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_cmd   (cmd),
        .i_geom  (geom),
        .i_rdata (mem_rdata),
        .o_req   (mem_req),
        .o_busy  (busy),
        .o_res   (res)
    );

    assign o_result_valid  = res.valid;
    assign o_found         = res.found;
    assign o_winning_color = res.color;

    `CPC_ASSERT_IMP(a_res_idle, o_result_valid, !busy, "result beat while busy")
    `CPC_ASSERT_IMP(a_color_found, o_result_valid && (o_winning_color != COLOR_EMPTY), o_found, "winning color without found")
    `CPC_ASSERT_NXT(a_no_res_wr, accept && ((i_kind == KIND_WRITE) || (i_kind == KIND_ROTATE)), !o_result_valid, "write or rotate gave a result beat")
    `CPC_ASSERT_NXT(a_win_busy, accept && (i_kind == KIND_WINNER), busy && !o_result_valid, "winner query did not start a scan")

endmodule

FILE: tb/sv/testbench.sv
// Self-checking bench for cyclic_progression_color_checker: a directed table, then
// random beats over several board geometries; checked against the table or a board model.
// Depends on cpc_pkg and the checker RTL only.
`timescale 1ns / 100ps

module testbench;
    import cpc_pkg::*;

    localparam logic REG_BOARD_SIZE = 1'b0;
    localparam logic REG_PROG_LEN   = 1'b1;
    localparam bit   TYPED = 1'b1;
    localparam bit   MODEL = 1'b0;
    localparam int   PEND_DEPTH = 4;

    typedef struct packed {
        logic   found;
        t_color color;
    } t_outcome;

    typedef struct packed {
        t_kind            kind;
        logic [POS_W-1:0] pos;
        t_color           color;
        logic             typed;
        logic             found;
        t_color           win;
    } t_row;

    // Default geometry after reset: 8 cells, progressions of 3.
    localparam int N_ROWS = 25;
    localparam t_row DIRECTED [0:N_ROWS-1] = '{
        '{KIND_WINNER, 7'd0,   COLOR_EMPTY, TYPED, 1'b0, COLOR_EMPTY}, // empty board
        '{KIND_MEMBER, 7'd0,   COLOR_EMPTY, TYPED, 1'b1, COLOR_EMPTY}, // empties form a run
        '{KIND_MEMBER, 7'd127, COLOR_EMPTY, TYPED, 1'b0, COLOR_EMPTY}, // off the board
        '{KIND_WRITE,  7'd127, 2'd3,        MODEL, 1'b0, COLOR_EMPTY}, // dropped
        '{KIND_WINNER, 7'd0,   COLOR_EMPTY, TYPED, 1'b0, COLOR_EMPTY},
        '{KIND_WRITE,  7'd0,   2'd3,        MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_WRITE,  7'd1,   2'd3,        MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_WRITE,  7'd2,   2'd3,        MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_WINNER, 7'd0,   COLOR_EMPTY, TYPED, 1'b1, 2'd3},
        '{KIND_MEMBER, 7'd1,   COLOR_EMPTY, MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_MEMBER, 7'd5,   COLOR_EMPTY, MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_ROTATE, 7'd0,   COLOR_EMPTY, MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_WINNER, 7'd0,   COLOR_EMPTY, MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_MEMBER, 7'd7,   COLOR_EMPTY, MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_WRITE,  7'd3,   2'd1,        MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_WRITE,  7'd5,   2'd2,        MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_WRITE,  7'd6,   2'd1,        MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_WRITE,  7'd4,   2'd2,        MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_MEMBER, 7'd3,   COLOR_EMPTY, MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_WINNER, 7'd0,   COLOR_EMPTY, MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_ROTATE, 7'd0,   COLOR_EMPTY, MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_WRITE,  7'd0,   COLOR_EMPTY, MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_MEMBER, 7'd0,   COLOR_EMPTY, MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_WINNER, 7'd0,   COLOR_EMPTY, MODEL, 1'b0, COLOR_EMPTY},
        '{KIND_MEMBER, 7'd85,  COLOR_EMPTY, TYPED, 1'b0, COLOR_EMPTY}
    };

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_kind            i_kind = KIND_WRITE;
    logic [POS_W-1:0] i_position = '0;
    t_color           i_color = COLOR_EMPTY;
    logic             o_result_valid;
    logic             o_found;
    t_color           o_winning_color;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_addr = REG_BOARD_SIZE;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    cyclic_progression_color_checker u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_position      (i_position),
        .i_color         (i_color),
        .o_result_valid  (o_result_valid),
        .o_found         (o_found),
        .o_winning_color (o_winning_color),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Board model
    t_color           board [MAX_CELLS];
    logic [CFG_W-1:0] board_size_reg;
    logic [CFG_W-1:0] prog_len_reg;

    // expected results in order, written by issue and read by the checker
    t_outcome pending_results [PEND_DEPTH];
    int       pend_wr;
    int       pend_rd;
    int       errors;
    int       gap_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int cells_in_use();
        int n;
        n = board_size_reg;
        if (n < 3) n = 3;
        if (n > MAX_CELLS) n = MAX_CELLS;
        return n;
    endfunction

    function automatic int run_length();
        int k;
        k = prog_len_reg;
        if (k < 2) k = 2;
        return k;
    endfunction

    // First color holding k equally spaced cells, scanning start cell then spacing.
    function automatic t_color winning_color_of(int n, int k);
        int  dmax;
        bit  same;
        dmax = (n - 1) / (k - 1);
        for (int i = 0; i < n; i++) begin
            if (board[i] == COLOR_EMPTY) continue;
            for (int d = 1; d <= dmax; d++) begin
                same = 1'b1;
                for (int j = 1; j < k; j++) begin
                    if (board[(i + j * d) % n] != board[i]) begin
                        same = 1'b0;
                        break;
                    end
                end
                if (same) return board[i];
            end
        end
        return COLOR_EMPTY;
    endfunction

    // Runs may wrap and count the same cell again.
    function automatic bit cell_in_progression(int n, int k, int loc);
        int     dmax;
        int     steps;
        int     run;
        t_color c;
        if (loc >= n) return 1'b0;
        c = board[loc];
        dmax = (n - 1) / (k - 1);
        for (int d = 1; d <= dmax; d++) begin
            steps = (n - 1) / d;
            run = 1;
            for (int j = 1; j <= steps; j++) begin
                if (board[(loc + n - j * d) % n] != c) break;
                run++;
            end
            for (int j = 1; j <= steps; j++) begin
                if (board[(loc + j * d) % n] != c) break;
                run++;
            end
            if (run >= k) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic apply_to_board(input t_kind kind, input logic [POS_W-1:0] pos,
                                  input t_color color, output bit gives,
                                  output t_outcome res);
        int     n;
        int     k;
        t_color first;
        n = cells_in_use();
        k = run_length();
        gives = 1'b0;
        res = '0;
        case (kind)
            KIND_WRITE: begin
                if (pos < n) board[pos] = color;
            end
            KIND_ROTATE: begin
                first = board[0];
                for (int i = 0; i + 1 < n; i++) board[i] = board[i + 1];
                board[n - 1] = first;
            end
            KIND_WINNER: begin
                gives = 1'b1;
                res.color = winning_color_of(n, k);
                res.found = (res.color != COLOR_EMPTY);
            end
            default: begin
                gives = 1'b1;
                res.found = cell_in_progression(n, k, int'(pos));
            end
        endcase
    endtask

    // Called at a clock edge; returns at the edge that takes the beat.
    task automatic issue(input t_kind kind, input logic [POS_W-1:0] pos, input t_color color,
                         input bit typed, input logic exp_found, input t_color exp_win);
        bit       gives;
        t_outcome want;
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_kind     <= kind;
        i_position <= pos;
        i_color    <= color;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        apply_to_board(kind, pos, color, gives, want);
        if (typed) begin
            want.found = exp_found;
            want.color = exp_win;
        end
        if (gives) begin
            pending_results[pend_wr % PEND_DEPTH] = want;
            pend_wr++;
        end
    endtask

    // Drain results, let a rotate finish, then hold off.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pend_wr != pend_rd) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (MAX_CELLS + 8) @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] k);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_BOARD_SIZE;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_addr  <= REG_PROG_LEN;
        i_cfg_wdata <= k;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board_size_reg = n;
        prog_len_reg   = k;
    endtask

    task automatic random_beats(input int count);
        int               r;
        int               n;
        t_kind            kind;
        logic [POS_W-1:0] pos;
        t_color           color;
        repeat (count) begin
            n = cells_in_use();
            r = $urandom_range(99);
            kind = (r < 50) ? KIND_WRITE : (r < 65) ? KIND_WINNER :
                   (r < 90) ? KIND_MEMBER : KIND_ROTATE;
            // mostly on the board, sometimes anywhere
            if ($urandom_range(99) < 85) pos = POS_W'($urandom_range(n - 1));
            else                         pos = POS_W'($urandom_range(127));
            color = t_color'($urandom_range(3));
            issue(kind, pos, color, MODEL, 1'b0, COLOR_EMPTY);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pend_wr == pend_rd) begin
                errors++;
                $display("%0t: unexpected result found=%0d color=%0d", $time,
                         o_found, o_winning_color);
            end else begin
                t_outcome want;
                want = pending_results[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (o_found !== want.found) begin
                    errors++;
                    $display("%0t: found expected %0d actual %0d", $time,
                             want.found, o_found);
                end
                if (o_winning_color !== want.color) begin
                    errors++;
                    $display("%0t: winning_color expected %0d actual %0d", $time,
                             want.color, o_winning_color);
                end
            end
        end
    end

    initial begin
        errors = 0;
        pend_wr = 0;
        pend_rd = 0;
        gap_pct = 6;
        board_size_reg = 8'd8;
        prog_len_reg = 8'd3;
        foreach (board[i]) board[i] = COLOR_EMPTY;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            issue(DIRECTED[r].kind, DIRECTED[r].pos, DIRECTED[r].color,
                  DIRECTED[r].typed, DIRECTED[r].found, DIRECTED[r].win);
        end

        set_geometry(8'd3, 8'd2);
        random_beats(8);
        set_geometry(8'd0, 8'd0);       // both saturate
        random_beats(8);
        set_geometry(8'd16, 8'd4);
        random_beats(10);

        gap_pct = 71;
        set_geometry(8'd5, 8'd1);
        random_beats(8);
        set_geometry(8'd12, 8'd255);    // no spacing fits
        random_beats(8);
        set_geometry(8'd128, 8'd2);
        random_beats(8);

        gap_pct = 0;
        set_geometry(8'd255, 8'd128);
        random_beats(6);
        set_geometry(8'd4, 8'd3);       // shrink: upper cells keep old contents
        random_beats(6);
        set_geometry(8'd10, 8'd3);
        random_beats(10);
        set_geometry(8'd7, 8'd7);
        random_beats(8);

        settle();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: cyclic_progression_color_checker.f
+incdir+rtl/core
rtl/core/cpc_pkg.sv
rtl/core/cpc_ram.sv
rtl/core/cpc_board.sv
rtl/core/cpc_ctrl.sv
rtl/core/cyclic_progression_color_checker.sv
tb/sv/testbench.sv
